// ===== src/sbus_frame_parser_defines.svh =====
// Assertion macros used by the SBUS frame parser checker.
`ifndef SBUS_FRAME_PARSER_DEFINES_SVH
`define SBUS_FRAME_PARSER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SFP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define SFP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/sfp_pkg.sv =====
// Package: constants, types and helpers of the SBUS frame parser.
`timescale 1ns / 1ps
package sfp_pkg;

  localparam int FRAME_BYTES   = 25;
  localparam int CHANNEL_COUNT = 16;
  localparam int FLAGS_AT      = 23;
  localparam int FOOTER_AT     = 24;
  localparam int CHAN_BITS     = 11;

  localparam int BUF_W  = FRAME_BYTES * 8;
  localparam int PAY_LO = 8;
  localparam int PAY_HI = FLAGS_AT * 8 - 1;
  localparam int FILL_W = $clog2(FRAME_BYTES + 1);
  localparam int CHAN_W = $clog2(CHANNEL_COUNT);

  localparam logic [7:0] HEADER_VALUE = 8'h0F;
  localparam logic [7:0] FOOTER_0     = 8'h00;
  localparam logic [7:0] FOOTER_1     = 8'h04;
  localparam logic [7:0] FOOTER_2     = 8'h14;
  localparam logic [7:0] FOOTER_3     = 8'h24;
  localparam logic [7:0] FOOTER_4     = 8'h34;

  typedef enum logic [1:0] {
    ST_FILL,
    ST_CHECK,
    ST_RESYNC,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic store;      // write rx_byte at the fill position
    logic drop_byte;  // shift the whole buffer down one byte
    logic next_chan;  // shift the payload down one channel
  } buf_cmd_t;

  typedef struct packed {
    logic rx_is_hdr;
    logic head_is_hdr;
    logic frame_ok;
  } buf_stat_t;

  function automatic logic footer_ok(input logic [7:0] f);
    return (f == FOOTER_0) || (f == FOOTER_1) || (f == FOOTER_2) ||
           (f == FOOTER_3) || (f == FOOTER_4);
  endfunction

endpackage

// ===== src/sfp_fbuf.sv =====
// Frame buffer with byte-shift resync and channel-shift unpack unit.
`timescale 1ns / 1ps
module sfp_fbuf (
  input  logic                          clk,
  input  logic [7:0]                    rx_byte,
  input  logic [sfp_pkg::FILL_W-1:0]    fill_count,
  input  sfp_pkg::buf_cmd_t             cmd,
  output sfp_pkg::buf_stat_t            stat,
  output logic [sfp_pkg::CHAN_BITS-1:0] channel_value,
  output logic [7:0]                    flags,
  output logic [7:0]                    footer_byte
);

  logic [sfp_pkg::BUF_W-1:0] frame_buffer;

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      for (int i = 0; i < sfp_pkg::FRAME_BYTES; i++) begin
        if (fill_count == sfp_pkg::FILL_W'(i)) begin
          frame_buffer[8*i +: 8] <= rx_byte;
        end
      end
    end else if (cmd.drop_byte) begin
      frame_buffer <= {8'h00, frame_buffer[sfp_pkg::BUF_W-1:8]};
    end else if (cmd.next_chan) begin
      // payload moves down by one channel; flags and footer stay put
      frame_buffer[sfp_pkg::PAY_HI:sfp_pkg::PAY_LO] <=
        {{sfp_pkg::CHAN_BITS{1'b0}},
         frame_buffer[sfp_pkg::PAY_HI:sfp_pkg::PAY_LO+sfp_pkg::CHAN_BITS]};
    end
  end

  assign flags         = frame_buffer[8*sfp_pkg::FLAGS_AT +: 8];
  assign footer_byte   = frame_buffer[8*sfp_pkg::FOOTER_AT +: 8];
  assign channel_value = frame_buffer[sfp_pkg::PAY_LO +: sfp_pkg::CHAN_BITS];

  always_comb begin
    stat.rx_is_hdr   = (rx_byte == sfp_pkg::HEADER_VALUE);
    stat.head_is_hdr = (frame_buffer[7:0] == sfp_pkg::HEADER_VALUE);
    stat.frame_ok    = stat.head_is_hdr && (flags[7:4] == 4'h0) &&
                       sfp_pkg::footer_ok(footer_byte);
  end

endmodule

// ===== src/sfp_ctrl.sv =====
// Sequencer: fill, check, byte-wise resync and channel emission.
`timescale 1ns / 1ps
module sfp_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  output logic                       out_valid,
  input  logic                       out_stall,
  input  sfp_pkg::buf_stat_t         stat,
  output sfp_pkg::buf_cmd_t          cmd,
  output logic [sfp_pkg::FILL_W-1:0] fill_count,
  output logic [sfp_pkg::CHAN_W-1:0] chan
);

  localparam logic [sfp_pkg::FILL_W-1:0] LAST_SLOT = sfp_pkg::FILL_W'(sfp_pkg::FRAME_BYTES - 1);
  localparam logic [sfp_pkg::CHAN_W-1:0] LAST_CHAN = sfp_pkg::CHAN_W'(sfp_pkg::CHANNEL_COUNT - 1);
  localparam logic [sfp_pkg::FILL_W-1:0] FILL_ONE  = sfp_pkg::FILL_W'(1);
  localparam logic [sfp_pkg::CHAN_W-1:0] CHAN_ONE  = sfp_pkg::CHAN_W'(1);

  sfp_pkg::state_t             state, state_next;
  logic [sfp_pkg::FILL_W-1:0]  fill_next;
  logic [sfp_pkg::CHAN_W-1:0]  chan_next;
  logic                        keep_byte;

  assign keep_byte = (fill_count != '0) || stat.rx_is_hdr;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= sfp_pkg::ST_FILL;
      fill_count <= '0;
      chan       <= '0;
    end else begin
      state      <= state_next;
      fill_count <= fill_next;
      chan       <= chan_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    fill_next  = fill_count;
    chan_next  = chan;
    unique case (state)
      sfp_pkg::ST_FILL: begin
        if (in_valid && keep_byte) begin
          fill_next = fill_count + FILL_ONE;
          if (fill_count == LAST_SLOT) begin
            state_next = sfp_pkg::ST_CHECK;
          end
        end
      end
      sfp_pkg::ST_CHECK: begin
        if (stat.frame_ok) begin
          chan_next  = '0;
          state_next = sfp_pkg::ST_EMIT;
        end else begin
          fill_next  = LAST_SLOT;
          state_next = sfp_pkg::ST_RESYNC;
        end
      end
      sfp_pkg::ST_RESYNC: begin
        if (fill_count == '0 || stat.head_is_hdr) begin
          state_next = sfp_pkg::ST_FILL;
        end else begin
          fill_next = fill_count - FILL_ONE;
        end
      end
      sfp_pkg::ST_EMIT: begin
        if (!out_stall) begin
          chan_next = chan + CHAN_ONE;
          if (chan == LAST_CHAN) begin
            fill_next  = '0;
            state_next = sfp_pkg::ST_FILL;
          end
        end
      end
      default: state_next = sfp_pkg::ST_FILL;
    endcase
  end

  // outputs
  always_comb begin
    cmd       = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    unique case (state)
      sfp_pkg::ST_FILL: begin
        in_stall  = 1'b0;
        cmd.store = in_valid && keep_byte;
      end
      sfp_pkg::ST_CHECK: begin
        cmd.drop_byte = !stat.frame_ok;
      end
      sfp_pkg::ST_RESYNC: begin
        cmd.drop_byte = (fill_count != '0) && !stat.head_is_hdr;
      end
      sfp_pkg::ST_EMIT: begin
        out_valid     = 1'b1;
        cmd.next_chan = !out_stall;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ===== src/sbus_frame_parser.sv =====
// Top level of the SBUS frame parser: byte input, per-channel results.
// Accepts one SBUS byte per transaction and returns sixteen channel
// transactions for every good 25-byte frame. Bytes other than the 0x0F
// header are dropped while the buffer is empty. After the 25th byte the
// block checks header, flags upper nibble and footer (0x00, 0x04, 0x14,
// 0x24 or 0x34). A good frame then emits channels 0..15 in order, one per
// cycle when out_stall is low; each result carries the four flag bits and
// the footer, and last_channel marks channel 15. The channels come out of a
// single shift unit that moves the 176-bit payload down by 11 bits per
// transaction. A bad frame is realigned at the next header byte after
// position 0 by shifting the buffer one byte per cycle, 1 to 25 bytes in
// all; kept bytes are not rechecked until the buffer is full again. in_stall
// stays high from the 25th byte until the check, realignment or emission has
// finished. No startup clearing is needed after reset.
`timescale 1ns / 1ps
module sbus_frame_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  channel_index,
  output logic [10:0] channel_value,
  output logic        aux_channel_17,
  output logic        aux_channel_18,
  output logic        frame_lost,
  output logic        failsafe,
  output logic [7:0]  footer_byte,
  output logic        last_channel
);

  sfp_pkg::buf_cmd_t          cmd;
  sfp_pkg::buf_stat_t         stat;
  logic [sfp_pkg::FILL_W-1:0] fill_count;
  logic [sfp_pkg::CHAN_W-1:0] chan;
  logic [7:0]                 flags;

  sfp_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .stat       (stat),
    .cmd        (cmd),
    .fill_count (fill_count),
    .chan       (chan)
  );

  sfp_fbuf u_fbuf (
    .clk           (clk),
    .rx_byte       (rx_byte),
    .fill_count    (fill_count),
    .cmd           (cmd),
    .stat          (stat),
    .channel_value (channel_value),
    .flags         (flags),
    .footer_byte   (footer_byte)
  );

  // flags byte: bit 0 ch17, bit 1 ch18, bit 2 frame lost, bit 3 failsafe
  assign aux_channel_17 = flags[0];
  assign aux_channel_18 = flags[1];
  assign frame_lost     = flags[2];
  assign failsafe       = flags[3];
  assign channel_index  = chan;
  assign last_channel   = (chan == sfp_pkg::CHAN_W'(sfp_pkg::CHANNEL_COUNT - 1));

endmodule

// ===== src/sfp_checker.sv =====
// Port-level checker for the SBUS frame parser, bound to the top level.
`timescale 1ns / 1ps
`include "sbus_frame_parser_defines.svh"
module sfp_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [3:0]  channel_index,
  input logic [10:0] channel_value,
  input logic        aux_channel_17,
  input logic        aux_channel_18,
  input logic        frame_lost,
  input logic        failsafe,
  input logic [7:0]  footer_byte,
  input logic        last_channel
);

  logic [27:0] result_bits;
  logic        out_wait;
  logic        out_step;
  logic        mid_step;
  logic [3:0]  index_next;

  // all result fields, so a stalled transaction is checked as a whole
  assign result_bits = {channel_index, channel_value, aux_channel_17, aux_channel_18,
                        frame_lost, failsafe, footer_byte, last_channel};
  assign out_wait    = out_valid && out_stall;
  assign out_step    = out_valid && !out_stall;
  assign mid_step    = out_step && !last_channel;
  assign index_next  = channel_index + 4'd1;

  `SFP_ASSERT_NEXT(a_out_hold, clk, rst, out_wait, out_valid && $stable(result_bits), "held result changed")
  `SFP_ASSERT_NOW(a_no_in_during_emit, clk, rst, out_valid, in_stall, "input taken during emission")
  `SFP_ASSERT_NEXT(a_frame_continues, clk, rst, mid_step, out_valid, "frame emission broke off")
  `SFP_ASSERT_NEXT(a_index_steps, clk, rst, mid_step, channel_index == $past(index_next), "index skipped")
  `SFP_ASSERT_NEXT(a_frame_ends, clk, rst, out_step && last_channel, !out_valid, "result after last")

endmodule

bind sbus_frame_parser sfp_checker u_sfp_checker (.*);

// ===== dv/tb.sv =====
// Self-checking testbench for the SBUS frame parser: byte stream in, channel results out.
`timescale 1ns / 1ps
module tb;
  import sfp_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  // Worst case after the last byte: check, realign up to 25 bytes, then settle.
  localparam int SETTLE_CYCLES = 40;

  // One decoded channel, laid out like the output ports.
  typedef struct packed {
    logic [3:0]  ch_index;
    logic [10:0] ch_value;
    logic        aux17;
    logic        aux18;
    logic        lost;
    logic        fs;
    logic [7:0]  footer;
    logic        last;
  } chan_result_t;

  typedef enum {PAY_RANDOM, PAY_ZERO, PAY_ONES, PAY_NO_HDR} payload_mode_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  rx_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  channel_index;
  logic [10:0] channel_value;
  logic        aux_channel_17;
  logic        aux_channel_18;
  logic        frame_lost;
  logic        failsafe;
  logic [7:0]  footer_byte;
  logic        last_channel;

  sbus_frame_parser dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .rx_byte        (rx_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .channel_index  (channel_index),
    .channel_value  (channel_value),
    .aux_channel_17 (aux_channel_17),
    .aux_channel_18 (aux_channel_18),
    .frame_lost     (frame_lost),
    .failsafe       (failsafe),
    .footer_byte    (footer_byte),
    .last_channel   (last_channel)
  );

  // Bytes waiting to be driven, and channel results the decoder predicts.
  logic [7:0]   rx_stream[$];
  chan_result_t expected_channels[$];

  // Shadow copy of the receive buffer.
  logic [7:0] frame_bytes[FRAME_BYTES];
  int         frame_fill = 0;

  int  send_idle_pct  = 0;
  int  recv_stall_pct = 0;
  bit  in_taken       = 1'b0;
  int  fail_count     = 0;
  int  bytes_taken    = 0;
  int  results_checked = 0;
  int  frames_decoded = 0;
  int  cycle_count    = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic bit footer_accepted(input logic [7:0] f);
    return f == FOOTER_0 || f == FOOTER_1 || f == FOOTER_2 || f == FOOTER_3 ||
           f == FOOTER_4;
  endfunction

  // Bad frame: slide the buffer down to the next header after byte 0, or empty it.
  function automatic void realign_frame();
    int  shift;
    bit  found;
    shift = frame_fill;
    found = 1'b0;
    for (int i = 1; i < frame_fill; i++) begin
      if (!found && frame_bytes[i] == HEADER_VALUE) begin
        shift = i;
        found = 1'b1;
      end
    end
    if (!found) begin
      frame_fill = 0;
    end else begin
      for (int i = 0; i < frame_fill - shift; i++)
        frame_bytes[i] = frame_bytes[i + shift];
      frame_fill = frame_fill - shift;
    end
  endfunction

  // Feed one accepted byte to the shadow buffer; a good full frame yields 16 channels.
  function automatic void decode_byte(input logic [7:0] b);
    logic [CHANNEL_COUNT*CHAN_BITS-1:0] payload_bits;
    logic [7:0]   flags;
    chan_result_t r;
    if (frame_fill >= FRAME_BYTES) frame_fill = 0;
    if (frame_fill == 0 && b != HEADER_VALUE) return;
    frame_bytes[frame_fill] = b;
    frame_fill++;
    if (frame_fill < FRAME_BYTES) return;
    flags = frame_bytes[FLAGS_AT];
    if (frame_bytes[0] != HEADER_VALUE || flags[7:4] != 4'h0 ||
        !footer_accepted(frame_bytes[FOOTER_AT])) begin
      realign_frame();
      return;
    end
    for (int i = 0; i < FLAGS_AT - 1; i++)
      payload_bits[i*8 +: 8] = frame_bytes[i + 1];
    for (int ch = 0; ch < CHANNEL_COUNT; ch++) begin
      r.ch_index = ch[3:0];
      r.ch_value = payload_bits[ch*CHAN_BITS +: CHAN_BITS];
      r.aux17    = flags[0];
      r.aux18    = flags[1];
      r.lost     = flags[2];
      r.fs       = flags[3];
      r.footer   = frame_bytes[FOOTER_AT];
      r.last     = (ch == CHANNEL_COUNT - 1);
      expected_channels.push_back(r);
    end
    frame_fill = 0;
  endfunction

  task automatic check_field(input string name, input logic [10:0] want,
                             input logic [10:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  // Monitor: everything is sampled at the rising edge.
  always @(posedge clk) begin
    chan_result_t got;
    chan_result_t want;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        decode_byte(rx_byte);
        in_taken = 1'b1;
        bytes_taken++;
      end
      if (out_valid && !out_stall) begin
        got = {channel_index, channel_value, aux_channel_17, aux_channel_18,
               frame_lost, failsafe, footer_byte, last_channel};
        results_checked++;
        if (expected_channels.size() == 0) begin
          $display("%0t: unexpected channel result, expected none, actual index %0d value %0d",
                   $time, got.ch_index, got.ch_value);
          fail_count++;
        end else begin
          want = expected_channels.pop_front();
          check_field("channel_index", 11'(want.ch_index), 11'(got.ch_index));
          check_field("channel_value", want.ch_value, got.ch_value);
          check_field("aux_channel_17", 11'(want.aux17), 11'(got.aux17));
          check_field("aux_channel_18", 11'(want.aux18), 11'(got.aux18));
          check_field("frame_lost", 11'(want.lost), 11'(got.lost));
          check_field("failsafe", 11'(want.fs), 11'(got.fs));
          check_field("footer_byte", 11'(want.footer), 11'(got.footer));
          check_field("last_channel", 11'(want.last), 11'(got.last));
          if (want.last) frames_decoded++;
        end
      end
    end
  end

  // Driver: inputs move on the falling edge; a stalled byte is held as is.
  always @(negedge clk) begin
    if (!rst) begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
      if (!in_valid || in_taken) begin
        in_taken = 1'b0;
        if (rx_stream.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          rx_byte  <= rx_stream.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles, %0d results still due", cycle_count,
               expected_channels.size());
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic logic [7:0] random_byte(input bit no_hdr);
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (no_hdr && b == HEADER_VALUE);
    return b;
  endfunction

  function automatic logic [7:0] random_footer();
    case ($urandom_range(4))
      0: return FOOTER_0;
      1: return FOOTER_1;
      2: return FOOTER_2;
      3: return FOOTER_3;
      default: return FOOTER_4;
    endcase
  endfunction

  task automatic push_byte(input logic [7:0] b);
    rx_stream.push_back(b);
  endtask

  // Header (optional), 22 payload bytes, flags, footer. hdr_at plants a header
  // byte in the payload so a rejected frame realigns there.
  task automatic queue_frame(input logic [7:0] flags, input logic [7:0] footer,
                             input payload_mode_t mode, input int hdr_at,
                             input bit with_hdr);
    logic [7:0] b;
    if (with_hdr) push_byte(HEADER_VALUE);
    for (int i = 1; i < FLAGS_AT; i++) begin
      case (mode)
        PAY_ZERO:   b = 8'h00;
        PAY_ONES:   b = 8'hFF;
        PAY_NO_HDR: b = random_byte(1'b1);
        default:    b = random_byte(1'b0);
      endcase
      if (i == hdr_at) b = HEADER_VALUE;
      push_byte(b);
    end
    push_byte(flags);
    push_byte(footer);
  endtask

  // Let the queue run dry and every predicted channel come back.
  task automatic wait_drained();
    while (rx_stream.size() > 0 || in_valid || expected_channels.size() > 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int send_pct[4];
    int recv_pct[4];
    send_pct = '{0, 73, 0, 30};
    recv_pct = '{0, 0, 73, 30};

    repeat (3) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // One round per idling mix, about a hundred bytes in all.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = send_pct[ph];
      recv_stall_pct = recv_pct[ph];
      case (ph)
        0: begin
          // Stray bytes while empty are dropped.
          push_byte(8'h00);
          push_byte(8'hFF);
          push_byte(8'hF0);
          // Bad footer with a header at byte 5: 20 bytes kept, not checked early.
          queue_frame(8'h00, 8'h01, PAY_NO_HDR, 5, 1'b1);
          // Completing it with the flags upper nibble set and no further
          // header empties the buffer.
          repeat (3) push_byte(random_byte(1'b1));
          push_byte(8'hF0);
          push_byte(FOOTER_2);
        end
        1: begin
          // Strays, then all-ones payload with every flag bit set.
          repeat (2) push_byte(random_byte(1'b1));
          queue_frame(8'h0F, FOOTER_4, PAY_ONES, -1, 1'b1);
        end
        default: begin
          queue_frame(8'($urandom_range(15)), random_footer(), PAY_RANDOM, -1, 1'b1);
        end
      endcase
      wait_drained();
    end

    $display("Run covered %0d accepted bytes and %0d channel results (%0d frames decoded)",
             bytes_taken, results_checked, frames_decoded);
    $display("across four idle/stall mixes, including rejected frames and realignment");
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/sfp_pkg.sv
src/sfp_fbuf.sv
src/sfp_ctrl.sv
src/sbus_frame_parser.sv
src/sfp_checker.sv
dv/tb.sv
